// File: hdl/edge_filter_stretch_binarize_unit_assert.svh
// Assertion macros used by the port checker of the edge filter unit
`ifndef EDGE_FILTER_STRETCH_BINARIZE_UNIT_ASSERT_SVH
`define EDGE_FILTER_STRETCH_BINARIZE_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define EFSB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define EFSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/efsb_pkg.sv
// Package: constants, types and helpers of the edge filter unit
`timescale 1ns / 1ps
package efsb_pkg;
   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 10;
   localparam int FIELD_DW = 10;
   localparam int MODE_W = 2;
   localparam int MAG_W  = 11;
   localparam int NUM_W  = 19;
   localparam int STRETCH_STEPS = 8;

   localparam logic [CSR_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IW-1:0] REG_FILTER_MODE  = 2'd2;

   localparam logic [MODE_W-1:0] MODE_VERTICAL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LAPLACIAN  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PREWITT    = 2'd3;

   localparam logic [FIELD_DW-1:0] RESET_DIM = 10'd512;
   localparam logic [MAG_W-1:0] MIN_RESET = 11'd2047;
   localparam logic [MAG_W-1:0] MAX_RESET = 11'd0;

   localparam logic [7:0] BIN_THRESHOLD = 8'd127;
   localparam logic [7:0] FULL_SCALE    = 8'd255;

   typedef logic [7:0] pixel_type;

   // Start request to the shared divider
   typedef struct packed {
      logic       start;
      logic [4:0] steps;
   } div_req_type;

   // Binarize a stretched value unless the mode keeps gray levels
   function automatic logic [7:0] shape_value(logic [7:0] val, logic [MODE_W-1:0] mode);
      logic [7:0] res;
      res = val;
      if (mode != MODE_PREWITT) begin
         res = (val > BIN_THRESHOLD) ? FULL_SCALE : 8'd0;
      end
      return res;
   endfunction
endpackage

// File: hdl/edge_filter_stretch_binarize_unit.sv
// Top level: 3x3 edge filter with frame store, min/max stretch and binarize
//
// Usage. Write frame_width, frame_height and filter_mode through the csr_
// port while the unit is idle. Issue a transaction by raising start while
// busy is low; req_action 0 loads req_pixel as the next raster pixel,
// req_action 1 reads the next result pixel of the frame.
// A load runs line store read, window shift, magnitude compute, store and
// min/max update. It gives no result. A read runs the shared restoring
// divider once to split the read position into row and column
// (log2(MAX_HEIGHT) steps) and, for interior pixels strictly between min
// and max, once more for the 8-bit stretch quotient. The result shows on
// rsp_value/rsp_last for one cycle with rsp_valid, in the first cycle with
// busy low. The receiver cannot stall; results are never held. Reset
// clears the sequencer, window, counters and min/max, and sets the
// registers to 512, 512 and mode 0. The line and magnitude stores are not
// cleared; no clearing pass runs, and the unit is ready right after reset.
`timescale 1ns / 1ps
module edge_filter_stretch_binarize_unit #(
   parameter int MAX_WIDTH  = efsb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = efsb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [7:0]                    req_pixel,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_value,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [efsb_pkg::CSR_IW-1:0]   csr_index,
   input  logic [efsb_pkg::CSR_DW-1:0]   csr_data
);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CB = $clog2(MAX_WIDTH);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = $clog2(DEPTH);
   localparam int TW = AW + 1;
   localparam int DW = (AW > efsb_pkg::NUM_W) ? AW : efsb_pkg::NUM_W;
   localparam int K  = (RB > efsb_pkg::STRETCH_STEPS) ? RB : efsb_pkg::STRETCH_STEPS;
   localparam int MW = efsb_pkg::MAG_W;

   typedef enum logic [3:0] {
      S_IDLE, S_LREAD, S_LSHIFT, S_LMAG, S_LSTORE, S_RPOS, S_RDIV, S_RNUM, S_RSTR
   } state_type;

   state_type state_ff;

   logic [efsb_pkg::FIELD_DW-1:0] width_ff, height_ff;
   logic [efsb_pkg::MODE_W-1:0]   mode_ff;
   logic [CB-1:0]  col_ff;
   logic [RB-1:0]  row_ff;
   logic [AW-1:0]  rdpos_ff;
   logic [MW-1:0]  min_ff, max_ff, mag_ff, mag_rd_ff;
   logic [7:0]     pixel_ff, top_rd_ff, mid_rd_ff;
   logic [7:0]     win_ff [9];
   logic [AW-1:0]  maddr_ff;
   logic           inner_ff;
   logic           valid_ff, last_ff;
   logic [7:0]     value_ff;

   logic [7:0]     top_mem [MAX_WIDTH];
   logic [7:0]     mid_mem [MAX_WIDTH];
   logic [MW-1:0]  mag_mem [DEPTH];

   logic [WW-1:0]  w_in;
   logic [HW-1:0]  h_in;
   logic [TW-1:0]  total_in;
   logic [CB-1:0]  col_in;
   logic [RB-1:0]  row_in;
   logic           accept_in;

   efsb_pkg::div_req_type div_req;
   logic [DW-1:0]  div_dividend, div_divisor;
   logic           div_done;
   logic [K-1:0]   div_q;
   logic [DW-1:0]  div_rem;

   // clamp the geometry registers to the supported range
   always_comb begin
      if (32'(width_ff) < 32'd3) w_in = WW'(3);
      else if (32'(width_ff) > 32'(MAX_WIDTH)) w_in = WW'(MAX_WIDTH);
      else w_in = WW'(width_ff);
      if (32'(height_ff) < 32'd3) h_in = HW'(3);
      else if (32'(height_ff) > 32'(MAX_HEIGHT)) h_in = HW'(MAX_HEIGHT);
      else h_in = HW'(height_ff);
      total_in = TW'(w_in) * TW'(h_in);
   end

   // wrap the load position for a changed geometry
   always_comb begin
      logic [RB:0] r;
      r = {1'b0, row_ff};
      col_in = col_ff;
      if (32'(col_ff) >= 32'(w_in)) begin
         col_in = '0;
         r = r + 1'b1;
      end
      if (32'(r) >= 32'(h_in)) r = '0;
      row_in = r[RB-1:0];
   end

   assign accept_in = start && (state_ff == S_IDLE);

   // window magnitude for the selected mode
   logic [MW-1:0] mag_in;
   always_comb begin
      logic signed [11:0] gx, gy, lap;
      logic [11:0] ax, ay, al;
      gx = 12'(win_ff[2]) + 12'(win_ff[5]) + 12'(win_ff[8])
         - 12'(win_ff[0]) - 12'(win_ff[3]) - 12'(win_ff[6]);
      gy = 12'(win_ff[6]) + 12'(win_ff[7]) + 12'(win_ff[8])
         - 12'(win_ff[0]) - 12'(win_ff[1]) - 12'(win_ff[2]);
      lap = {1'b0, win_ff[4], 3'b000}
         - 12'(win_ff[0]) - 12'(win_ff[1]) - 12'(win_ff[2]) - 12'(win_ff[3])
         - 12'(win_ff[5]) - 12'(win_ff[6]) - 12'(win_ff[7]) - 12'(win_ff[8]);
      ax = gx[11] ? 12'(-gx) : 12'(gx);
      ay = gy[11] ? 12'(-gy) : 12'(gy);
      al = lap[11] ? 12'(-lap) : 12'(lap);
      case (mode_ff)
         efsb_pkg::MODE_VERTICAL:   mag_in = ax[MW-1:0];
         efsb_pkg::MODE_HORIZONTAL: mag_in = ay[MW-1:0];
         efsb_pkg::MODE_LAPLACIAN:  mag_in = al[MW-1:0];
         default:                   mag_in = MW'(ax + ay);
      endcase
   end

   // divider requests: position split, then stretch quotient
   logic [MW-1:0] diff_in;
   assign diff_in = mag_rd_ff - min_ff;
   always_comb begin
      div_req.start = 1'b0;
      div_req.steps = 5'(RB);
      div_dividend  = DW'(rdpos_ff);
      div_divisor   = DW'(w_in);
      case (state_ff)
         S_RPOS: div_req.start = 1'b1;
         S_RNUM: begin
            div_req.start = 1'b1;
            div_req.steps = 5'(efsb_pkg::STRETCH_STEPS);
            div_dividend  = DW'({diff_in, 8'd0}) - DW'(diff_in);
            div_divisor   = DW'(max_ff - min_ff);
         end
         default: ;
      endcase
   end

   efsb_div #(.DW(DW), .K(K)) u_div (
      .clock(clock), .reset(reset), .req(div_req),
      .dividend(div_dividend), .divisor(div_divisor),
      .done(div_done), .quotient(div_q), .remainder(div_rem)
   );

   // line stores
   always_ff @(posedge clock) begin
      if (state_ff == S_LREAD) begin
         top_rd_ff <= top_mem[col_ff];
         mid_rd_ff <= mid_mem[col_ff];
      end
      if (state_ff == S_LSHIFT) begin
         top_mem[col_ff] <= mid_rd_ff;
         mid_mem[col_ff] <= pixel_ff;
      end
   end

   // magnitude store
   always_ff @(posedge clock) begin
      if (state_ff == S_LSTORE && inner_ff) mag_mem[maddr_ff] <= mag_ff;
      if (state_ff == S_RPOS) mag_rd_ff <= mag_mem[rdpos_ff];
   end

   // sequencer, counters and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= efsb_pkg::RESET_DIM;
         height_ff <= efsb_pkg::RESET_DIM;
         mode_ff   <= efsb_pkg::MODE_VERTICAL;
         col_ff    <= '0;
         row_ff    <= '0;
         rdpos_ff  <= '0;
         min_ff    <= efsb_pkg::MIN_RESET;
         max_ff    <= efsb_pkg::MAX_RESET;
         valid_ff  <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         valid_ff <= 1'b0;
         if (csr_write_enable) begin
            case (csr_index)
               efsb_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_data;
               efsb_pkg::REG_FRAME_HEIGHT: height_ff <= csr_data;
               efsb_pkg::REG_FILTER_MODE:  mode_ff   <= csr_data[efsb_pkg::MODE_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept_in) begin
                  pixel_ff <= req_pixel;
                  if (!req_action) begin
                     col_ff <= col_in;
                     row_ff <= row_in;
                     if (col_in == '0 && row_in == '0) begin
                        min_ff   <= efsb_pkg::MIN_RESET;
                        max_ff   <= efsb_pkg::MAX_RESET;
                        rdpos_ff <= '0;
                     end
                     state_ff <= S_LREAD;
                  end else begin
                     if (TW'(rdpos_ff) >= total_in) rdpos_ff <= '0;
                     state_ff <= S_RPOS;
                  end
               end
            end
            S_LREAD: state_ff <= S_LSHIFT;
            S_LSHIFT: begin
               win_ff[0] <= win_ff[1]; win_ff[1] <= win_ff[2]; win_ff[2] <= top_rd_ff;
               win_ff[3] <= win_ff[4]; win_ff[4] <= win_ff[5]; win_ff[5] <= mid_rd_ff;
               win_ff[6] <= win_ff[7]; win_ff[7] <= win_ff[8]; win_ff[8] <= pixel_ff;
               inner_ff  <= (32'(row_ff) >= 32'd2) && (32'(col_ff) >= 32'd2);
               maddr_ff  <= AW'((32'(row_ff) - 32'd1) * 32'(w_in) + 32'(col_ff) - 32'd1);
               state_ff  <= S_LMAG;
            end
            S_LMAG: begin
               mag_ff   <= mag_in;
               state_ff <= S_LSTORE;
            end
            S_LSTORE: begin
               if (inner_ff) begin
                  if (mag_ff < min_ff) min_ff <= mag_ff;
                  if (mag_ff > max_ff) max_ff <= mag_ff;
               end
               if (32'(col_ff) + 32'd1 >= 32'(w_in)) begin
                  col_ff <= '0;
                  if (32'(row_ff) + 32'd1 >= 32'(h_in)) row_ff <= '0;
                  else row_ff <= row_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_RPOS: state_ff <= S_RDIV;
            S_RDIV: begin
               if (div_done) begin
                  if (!((32'(div_q) >= 32'd1) && (32'(div_q) + 32'd1 < 32'(h_in))
                        && (32'(div_rem) >= 32'd1) && (32'(div_rem) + 32'd1 < 32'(w_in))
                        && (max_ff > min_ff))) begin
                     value_ff <= 8'd0;
                     valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else if (mag_rd_ff <= min_ff) begin
                     value_ff <= efsb_pkg::shape_value(8'd0, mode_ff);
                     valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else if (mag_rd_ff >= max_ff) begin
                     value_ff <= efsb_pkg::shape_value(efsb_pkg::FULL_SCALE, mode_ff);
                     valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_RNUM;
                  end
                  last_ff <= (TW'(rdpos_ff) + 1'b1 == total_in);
                  if (TW'(rdpos_ff) + 1'b1 == total_in) rdpos_ff <= '0;
                  else rdpos_ff <= rdpos_ff + 1'b1;
               end
            end
            S_RNUM: state_ff <= S_RSTR;
            S_RSTR: begin
               if (div_done) begin
                  value_ff <= efsb_pkg::shape_value(div_q[7:0], mode_ff);
                  valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;
   assign rsp_last  = last_ff;
endmodule

// File: hdl/efsb_div.sv
// Restoring divider: one quotient bit per cycle, shared by all divisions
`timescale 1ns / 1ps
module efsb_div #(
   parameter int DW = 19,
   parameter int K  = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  efsb_pkg::div_req_type req,
   input  logic [DW-1:0]        dividend,
   input  logic [DW-1:0]        divisor,
   output logic                 done,
   output logic [K-1:0]         quotient,
   output logic [DW-1:0]        remainder
);
   localparam int SW = DW + K;

   logic [DW-1:0] rem_ff;
   logic [SW-1:0] sd_ff;
   logic [K-1:0]  q_ff;
   logic [4:0]    cnt_ff;
   logic          run_ff;
   logic          done_ff;
   logic [SW:0]   trial_in;

   // trial subtract of the shifted divisor
   assign trial_in = {1'b0, {K{1'b0}}, rem_ff} - {1'b0, sd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff <= dividend;
            sd_ff  <= SW'(divisor) << (req.steps - 5'd1);
            q_ff   <= '0;
            cnt_ff <= req.steps;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (!trial_in[SW]) begin
               rem_ff <= trial_in[DW-1:0];
               q_ff   <= {q_ff[K-2:0], 1'b1};
            end else begin
               q_ff   <= {q_ff[K-2:0], 1'b0};
            end
            sd_ff  <= sd_ff >> 1;
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;
endmodule

// File: hdl/efsb_checker.sv
// Port-level checker for the edge filter unit, bound to the top level
`timescale 1ns / 1ps
`include "edge_filter_stretch_binarize_unit_assert.svh"
module efsb_port_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   `EFSB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `EFSB_ASSERT_NOW(a_result_after_work, clock, reset, rsp_valid, !busy && $past(busy))
   `EFSB_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
endmodule

bind edge_filter_stretch_binarize_unit efsb_port_checker u_efsb_port_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid)
);

// File: tb/efsb_checker.sv
// Checker: predicts edge filter results and compares them with the unit's output
`timescale 1ns / 1ps
module efsb_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_action,
   input  logic [7:0]                    req_pixel,
   input  logic                          rsp_valid,
   input  logic [7:0]                    rsp_value,
   input  logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [efsb_pkg::CSR_IW-1:0]   csr_index,
   input  logic [efsb_pkg::CSR_DW-1:0]   csr_data,
   output int                            errors,
   output int                            pending
);
   localparam int MW = efsb_pkg::DEF_MAX_WIDTH;
   localparam int MH = efsb_pkg::DEF_MAX_HEIGHT;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } pixel_out_type;

   pixel_out_type      pixel_out_q[$];

   logic [9:0]                   width_reg;
   logic [9:0]                   height_reg;
   logic [efsb_pkg::MODE_W-1:0]  mode_reg;
   logic [7:0]                   line_mem[0:2*MW-1];
   logic [7:0]                   win[0:8];
   logic [efsb_pkg::MAG_W-1:0]   mag_mem[0:MW*MH-1];
   logic [efsb_pkg::MAG_W-1:0]   mag_lo;
   logic [efsb_pkg::MAG_W-1:0]   mag_hi;
   int                           load_col;
   int                           load_row;
   int                           read_pos;

   function automatic int clamp_dim(logic [9:0] raw, int hi);
      if (raw < 3) return 3;
      if (raw > hi) return hi;
      return int'(raw);
   endfunction

   // Edge magnitude of the current window for the selected mode
   function automatic logic [efsb_pkg::MAG_W-1:0] window_mag();
      int gx, gy, lap, sum, both;
      gx = (win[2] + win[5] + win[8]) - (win[0] + win[3] + win[6]);
      gy = (win[6] + win[7] + win[8]) - (win[0] + win[1] + win[2]);
      sum = 0;
      for (int k = 0; k < 9; k++) sum += win[k];
      lap = 9 * win[4] - sum;
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      if (lap < 0) lap = -lap;
      both = gx + gy;
      case (mode_reg)
         efsb_pkg::MODE_VERTICAL:   return gx[efsb_pkg::MAG_W-1:0];
         efsb_pkg::MODE_HORIZONTAL: return gy[efsb_pkg::MAG_W-1:0];
         efsb_pkg::MODE_LAPLACIAN:  return lap[efsb_pkg::MAG_W-1:0];
         default:                   return both[efsb_pkg::MAG_W-1:0];
      endcase
   endfunction

   // Advance the load position and update the window, store and range
   task automatic load_pixel(logic [7:0] p);
      int w, h;
      logic [7:0] top, mid;
      logic [efsb_pkg::MAG_W-1:0] m;
      w = clamp_dim(width_reg, MW);
      h = clamp_dim(height_reg, MH);
      if (load_col >= w) begin
         load_col = 0;
         load_row++;
      end
      if (load_row >= h) load_row = 0;
      if (load_row == 0 && load_col == 0) begin
         mag_lo = efsb_pkg::MIN_RESET;
         mag_hi = efsb_pkg::MAX_RESET;
         read_pos = 0;
      end
      top = line_mem[load_col];
      mid = line_mem[MW + load_col];
      line_mem[load_col] = mid;
      line_mem[MW + load_col] = p;
      win[0] = win[1]; win[1] = win[2]; win[2] = top;
      win[3] = win[4]; win[4] = win[5]; win[5] = mid;
      win[6] = win[7]; win[7] = win[8]; win[8] = p;
      if (load_row >= 2 && load_col >= 2) begin
         m = window_mag();
         mag_mem[(load_row - 1) * w + load_col - 1] = m;
         if (m < mag_lo) mag_lo = m;
         if (m > mag_hi) mag_hi = m;
      end
      load_col++;
      if (load_col >= w) begin
         load_col = 0;
         load_row++;
         if (load_row >= h) load_row = 0;
      end
   endtask

   // Stretch the next stored magnitude and queue the expected pixel
   task automatic read_pixel();
      int w, h, total, r, c, v, val;
      pixel_out_type e;
      w = clamp_dim(width_reg, MW);
      h = clamp_dim(height_reg, MH);
      total = w * h;
      if (read_pos >= total) read_pos = 0;
      r = read_pos / w;
      c = read_pos % w;
      val = 0;
      if (r >= 1 && r + 1 < h && c >= 1 && c + 1 < w && mag_hi > mag_lo) begin
         v = int'(mag_mem[read_pos]);
         if (v <= mag_lo) val = 0;
         else if (v >= mag_hi) val = 255;
         else val = (255 * (v - mag_lo)) / (mag_hi - mag_lo);
         if (mode_reg != efsb_pkg::MODE_PREWITT)
            val = (val > efsb_pkg::BIN_THRESHOLD) ? 255 : 0;
      end
      e.value = val[7:0];
      e.last = (read_pos + 1 == total);
      read_pos = e.last ? 0 : read_pos + 1;
      pixel_out_q.push_back(e);
   endtask

   always @(posedge clock) begin
      pixel_out_type e;
      if (reset) begin
         width_reg = efsb_pkg::RESET_DIM;
         height_reg = efsb_pkg::RESET_DIM;
         mode_reg = efsb_pkg::MODE_VERTICAL;
         for (int k = 0; k < 9; k++) win[k] = 8'd0;
         mag_lo = efsb_pkg::MIN_RESET;
         mag_hi = efsb_pkg::MAX_RESET;
         load_col = 0;
         load_row = 0;
         read_pos = 0;
         pixel_out_q.delete();
         errors = 0;
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               efsb_pkg::REG_FRAME_WIDTH:  width_reg = csr_data;
               efsb_pkg::REG_FRAME_HEIGHT: height_reg = csr_data;
               efsb_pkg::REG_FILTER_MODE:  mode_reg = csr_data[efsb_pkg::MODE_W-1:0];
               default: ;
            endcase
         end
         // compare the result transaction with the oldest expectation
         if (rsp_valid) begin
            if (pixel_out_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result value=%0d last=%0b",
                           $realtime, rsp_value, rsp_last);
            end else begin
               e = pixel_out_q.pop_front();
               if (rsp_value !== e.value || rsp_last !== e.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch value exp %0d got %0d, last exp %0b got %0b",
                              $realtime, e.value, rsp_value, e.last, rsp_last);
               end
            end
         end
         // accepted request transaction
         if (start && !busy) begin
            if (req_action) read_pixel();
            else load_pixel(req_pixel);
         end
      end
      pending = pixel_out_q.size();
   end
endmodule

// File: tb/tb_top.sv
// Testbench top: stimulus, watchdog and verdict for the edge filter unit
`timescale 1ns / 1ps
module tb_top;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEM_TARGET = 950;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_action = 1'b0;
   logic [7:0]                   req_pixel = 8'd0;
   logic                         rsp_valid;
   logic [7:0]                   rsp_value;
   logic                         rsp_last;
   logic                         csr_write_enable = 1'b0;
   logic [efsb_pkg::CSR_IW-1:0]  csr_index = efsb_pkg::REG_FRAME_WIDTH;
   logic [efsb_pkg::CSR_DW-1:0]  csr_data = '0;
   int                           errors;
   int                           pending;
   int                           items = 0;
   int                           idle_cycles = 0;
   int                           eff_w = 512;
   int                           eff_h = 512;
   bit                           filled = 1'b0;

   always #5 clock = ~clock;

   edge_filter_stretch_binarize_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   efsb_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending)
   );

   // Stop a run that makes no progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic int clamp_dim(logic [9:0] raw);
      if (raw < 3) return 3;
      if (raw > 512) return 512;
      return int'(raw);
   endfunction

   // Issue one transaction, idling first by the current phase's rate
   task automatic send(logic action, logic [7:0] pix);
      int pct, gap;
      pct = (items < 350) ? 38 : (items < 700) ? 64 : 0;
      gap = ($urandom_range(99) < pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= action;
      req_pixel <= pix;
      do @(posedge clock); while (busy);
      items++;
   endtask

   // Hold off until every expected result is in and the unit has settled
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(logic [efsb_pkg::CSR_IW-1:0] idx,
                          logic [efsb_pkg::CSR_DW-1:0] data);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == efsb_pkg::REG_FRAME_WIDTH && clamp_dim(data) != eff_w) begin
         eff_w = clamp_dim(data);
         filled = 1'b0;
      end
      if (idx == efsb_pkg::REG_FRAME_HEIGHT && clamp_dim(data) != eff_h) begin
         eff_h = clamp_dim(data);
         filled = 1'b0;
      end
   endtask

   function automatic logic [7:0] make_pixel(int kind, int i, logic [7:0] base);
      case (kind)
         0: return 8'($urandom);
         1: return base;
         2: return (((i % eff_w) + (i / eff_w)) & 1) ? 8'd255 : 8'd0;
         default: return base ^ 8'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic load_run(int first, int n, int kind, logic [7:0] base);
      for (int i = first; i < first + n; i++) send(1'b0, make_pixel(kind, i, base));
   endtask

   task automatic read_run(int n);
      repeat (n) send(1'b1, 8'($urandom));
   endtask

   // One frame: loads, sometimes broken by early reads, then a readout
   task automatic run_frame(int kind);
      int total, k, pick;
      logic [7:0] base;
      total = eff_w * eff_h;
      base = 8'($urandom);
      if (filled && $urandom_range(99) < 20) begin
         // reads mid-frame see stale magnitudes from the previous frame
         k = $urandom_range(1, total - 1);
         load_run(0, k, kind, base);
         read_run($urandom_range(1, total));
         load_run(k, total - k, kind, base);
      end else begin
         load_run(0, total, kind, base);
      end
      filled = 1'b1;
      pick = $urandom_range(9);
      if (pick < 6) read_run(total);
      else if (pick < 8) read_run($urandom_range(1, total));
      else read_run(total + $urandom_range(1, total));
   endtask

   initial begin
      bit wide_done, tall_done;
      wide_done = 1'b0;
      tall_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest frame, extreme pixels, single interior pixel gives a flat range
      set_reg(efsb_pkg::REG_FRAME_WIDTH, 10'd3);
      set_reg(efsb_pkg::REG_FRAME_HEIGHT, 10'd3);
      set_reg(efsb_pkg::REG_FILTER_MODE, 10'(efsb_pkg::MODE_VERTICAL));
      run_frame(2);
      // sizes below the floor clamp up, prewitt gray output
      set_reg(efsb_pkg::REG_FRAME_WIDTH, 10'd0);
      set_reg(efsb_pkg::REG_FRAME_HEIGHT, 10'd2);
      set_reg(efsb_pkg::REG_FILTER_MODE, 10'(efsb_pkg::MODE_PREWITT));
      run_frame(0);

      // random frames
      while (items < ITEM_TARGET) begin
         if (!wide_done && items > 400) begin
            // widest clamped size: part of the top border row, then a smaller
            // size wraps the load position, and two rows finish that frame
            set_reg(efsb_pkg::REG_FRAME_WIDTH, 10'h3FF);
            set_reg(efsb_pkg::REG_FRAME_HEIGHT, 10'd1);
            load_run(0, 150, 0, 8'd0);
            read_run(100);
            set_reg(efsb_pkg::REG_FRAME_WIDTH, 10'd3);
            set_reg(efsb_pkg::REG_FRAME_HEIGHT, 10'd3);
            load_run(0, 6, 0, 8'd0);
            wide_done = 1'b1;
         end else if (!tall_done && items > 750) begin
            // tallest clamped size: 30 rows, reads of loaded rows, then a
            // shorter size wraps the load row back to the frame start
            set_reg(efsb_pkg::REG_FRAME_WIDTH, 10'd1);
            set_reg(efsb_pkg::REG_FRAME_HEIGHT, 10'd513);
            load_run(0, 90, 0, 8'd0);
            read_run(60);
            set_reg(efsb_pkg::REG_FRAME_WIDTH, 10'($urandom_range(0, 12)));
            set_reg(efsb_pkg::REG_FRAME_HEIGHT, 10'($urandom_range(0, 10)));
            tall_done = 1'b1;
         end else begin
            if ($urandom_range(99) < 40) begin
               set_reg(efsb_pkg::REG_FRAME_WIDTH, 10'($urandom_range(0, 12)));
               set_reg(efsb_pkg::REG_FRAME_HEIGHT, 10'($urandom_range(0, 10)));
            end
            if ($urandom_range(99) < 50)
               set_reg(efsb_pkg::REG_FILTER_MODE,
                       10'($urandom_range(efsb_pkg::MODE_VERTICAL, efsb_pkg::MODE_PREWITT)));
            run_frame($urandom_range(0, 3));
         end
      end

      // wait for the last results, then settle
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
